### rtl/core/bn_pkg.sv
// Shared types and constants of the batch normalization block.
// No dependencies; used by bn_fifo, bn_loader, bn_datapath and the top level.
`timescale 1ns / 1ps
package bn_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned ChanW   = 6;
  localparam int unsigned CoefW   = 32;
  localparam int unsigned RegIdxW = 2;
  localparam int unsigned RegDataW = 16;

  typedef enum logic [RegIdxW-1:0] {
    REG_EPSILON    = 2'd0,
    REG_USE_WEIGHT = 2'd1,
    REG_USE_BIAS   = 2'd2
  } reg_idx_e;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_NORM = 1'b1
  } op_e;

  typedef struct packed {
    logic                        operation;
    logic [ChanW-1:0]            channel;
    logic signed [SampleW-1:0]   sample;
    logic signed [SampleW-1:0]   mean;
    logic [SampleW-1:0]          variance;
    logic signed [SampleW-1:0]   weight;
    logic signed [SampleW-1:0]   bias;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleW-1:0] result;
    logic [ChanW-1:0]          result_channel;
    logic                      saturated;
  } out_item_t;

  // Coefficient load handed from the coefficient unit to the table writer.
  typedef struct packed {
    logic                    valid;
    logic [ChanW-1:0]        channel;
    logic signed [CoefW-1:0] scale;
    logic signed [CoefW-1:0] shift;
    logic                    clipped;
  } coef_wr_t;

  typedef enum logic [2:0] {
    LD_IDLE,
    LD_SQRT,
    LD_DIV,
    LD_SHIFT,
    LD_WRITE
  } ld_state_e;

endpackage

### rtl/core/bn_stream_if.sv
// Valid/ready channel carrying one payload item.
// Depends on nothing; payload type set by parameter.
`timescale 1ns / 1ps
interface bn_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/bn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module bn_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

### rtl/core/bn_fifo.sv
// Short item queue between the front end and the sample datapath.
// Depends on bn_pkg.
`timescale 1ns / 1ps
module bn_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bn_pkg::in_item_t  push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output bn_pkg::in_item_t  pop_data_o,
  output logic              empty_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  bn_pkg::in_item_t       buf_q [Depth];
  logic [PtrW-1:0]        wr_q, wr_d, rd_q, rd_d;
  logic [$clog2(Depth+1)-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == ($clog2(Depth+1))'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = buf_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= push_data_i;
    end
  end
endmodule

### rtl/core/bn_loader.sv
// Coefficient unit: iterative square root, restoring divide and shift
// product for one channel load. Depends on bn_pkg.
`timescale 1ns / 1ps
module bn_loader (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  bn_pkg::in_item_t     item_i,
  input  logic [15:0]          epsilon_i,
  input  logic                 use_weight_i,
  input  logic                 use_bias_i,
  output logic                 busy_o,
  output bn_pkg::coef_wr_t     wr_o
);
  bn_pkg::ld_state_e state_q, state_d;

  // square root of v<<32 (v < 2^25, so operand < 2^57): 29 steps of 2 bits
  logic [57:0] rem_q, rem_d;     // remainder operand (n)
  logic [57:0] root_q, root_d;   // r
  logic [57:0] bit_q, bit_d;
  logic [5:0]  step_q, step_d;
  logic [15:0] mag_q;
  logic        neg_q;
  logic [5:0]  ch_q;
  logic signed [15:0] mean_q, bias_q;
  // division: (mag<<32 + s/2) / s, quotient up to 49 bits
  logic [48:0] num_q, num_d;
  logic [29:0] div_rem_q, div_rem_d;
  logic [48:0] quo_q, quo_d;
  logic signed [31:0] scale_q, scale_d;
  logic        clip_q, clip_d;
  logic signed [31:0] shift_q, shift_d;

  logic [24:0] v;
  logic [16:0] wmag;
  logic signed [16:0] w;
  logic [58:0] trial;
  logic [30:0] dtrial;
  logic [28:0] s;
  logic signed [47:0] prod;
  logic signed [47:0] rnd;

  assign v    = {1'b0, item_i.variance, 8'd0} + {9'd0, epsilon_i};
  assign w    = use_weight_i ? 17'(item_i.weight) : 17'sd256;
  assign wmag = w[16] ? 17'(-w) : 17'(w);
  assign s    = root_q[28:0];
  assign trial = {1'b0, rem_q} - ({1'b0, root_q} + {1'b0, bit_q});
  assign dtrial = {div_rem_q, num_q[48]} - {2'd0, s};
  assign prod = 48'(mean_q) * 48'(scale_q);
  assign rnd  = prod[47] ? -48'((-prod + 48'sd32768) >>> 16)
                         : 48'((prod + 48'sd32768) >>> 16);

  assign busy_o = (state_q != bn_pkg::LD_IDLE);

  always_comb begin
    state_d = state_q;
    rem_d = rem_q; root_d = root_q; bit_d = bit_q; step_d = step_q;
    num_d = num_q; div_rem_d = div_rem_q; quo_d = quo_q;
    scale_d = scale_q; clip_d = clip_q; shift_d = shift_q;
    wr_o = '0;
    case (state_q)
      bn_pkg::LD_IDLE: begin
        if (start_i) begin
          rem_d  = {1'b0, v, 32'd0};
          root_d = '0;
          bit_d  = 58'd1 << 56;
          step_d = 6'd29;
          state_d = (v == '0) ? bn_pkg::LD_SHIFT : bn_pkg::LD_SQRT;
          clip_d  = (v == '0);
          scale_d = w[16] ? 32'sh8000_0000 : ((w == '0) ? 32'sd0 : 32'sh7FFF_FFFF);
        end
      end
      bn_pkg::LD_SQRT: begin
        if (!trial[58]) begin
          rem_d  = trial[57:0];
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d  = bit_q >> 2;
        step_d = step_q - 1'b1;
        if (step_q == 6'd1) begin
          state_d = bn_pkg::LD_DIV;
          step_d  = 6'd49;
        end
      end
      bn_pkg::LD_DIV: begin
        if (!dtrial[30]) begin
          div_rem_d = dtrial[29:0];
          quo_d = {quo_q[47:0], 1'b1};
        end else begin
          div_rem_d = {div_rem_q[28:0], num_q[48]};
          quo_d = {quo_q[47:0], 1'b0};
        end
        num_d  = {num_q[47:0], 1'b0};
        step_d = step_q - 1'b1;
        if (step_q == 6'd1) begin
          state_d = bn_pkg::LD_SHIFT;
          if (neg_q) begin
            clip_d  = (quo_d > 49'h8000_0000);
            scale_d = clip_d ? 32'sh8000_0000 : -32'(quo_d);
          end else begin
            clip_d  = (quo_d > 49'h7FFF_FFFF);
            scale_d = clip_d ? 32'sh7FFF_FFFF : 32'(quo_d);
          end
        end
      end
      bn_pkg::LD_SHIFT: begin
        shift_d = 32'(bias_q) - 32'(rnd);
        state_d = bn_pkg::LD_WRITE;
      end
      bn_pkg::LD_WRITE: begin
        wr_o.valid   = 1'b1;
        wr_o.channel = ch_q;
        wr_o.scale   = scale_q;
        wr_o.shift   = shift_q;
        wr_o.clipped = clip_q;
        state_d = bn_pkg::LD_IDLE;
      end
      default: state_d = bn_pkg::LD_IDLE;
    endcase
    // load the divider operand once the root settles
    if (state_q == bn_pkg::LD_SQRT && step_q == 6'd1) begin
      num_d     = {1'b0, mag_q, 32'd0} + 49'(root_d[28:1]);
      div_rem_d = '0;
      quo_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bn_pkg::LD_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; root_q <= root_d; bit_q <= bit_d;
    num_q <= num_d; div_rem_q <= div_rem_d; quo_q <= quo_d;
    scale_q <= scale_d; clip_q <= clip_d; shift_q <= shift_d;
    if (state_q == bn_pkg::LD_IDLE && start_i) begin
      mag_q  <= wmag[15:0];
      neg_q  <= w[16];
      ch_q   <= item_i.channel;
      mean_q <= item_i.mean;
      bias_q <= use_bias_i ? item_i.bias : 16'sd0;
    end
  end
endmodule

### rtl/core/bn_datapath.sv
// Back end: coefficient tables and the sample multiply-add pipeline.
// Depends on bn_pkg and bn_ram.
`timescale 1ns / 1ps
module bn_datapath #(
  parameter int unsigned Channels  = 64,
  parameter int unsigned DataWidth = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bn_pkg::coef_wr_t  wr_i,
  input  logic              in_valid_i,
  input  bn_pkg::in_item_t  in_item_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output bn_pkg::out_item_t out_item_o,
  input  logic              out_ready_i
);
  localparam int unsigned AddrW = (Channels > 1) ? $clog2(Channels) : 1;
  localparam logic signed [47:0] Hi = 48'sd1 <<< (DataWidth - 1);

  // stage 1: table read, stage 2: multiply, stage 3: round/saturate
  logic        v1_q, v2_q, v3_q;
  logic        adv1, adv2, adv3;
  logic [5:0]  ch1_q, ch2_q;
  logic        oor1_q, oor2_q;
  logic signed [15:0] smp1_q;
  logic signed [31:0] scale_rd, shift_rd;
  logic [0:0]  clip_rd;
  logic signed [47:0] acc2_q;
  logic        clip2_q;
  logic [AddrW-1:0] raddr;
  logic        oor;
  logic signed [47:0] r;
  bn_pkg::out_item_t  res_q;

  assign oor   = ({26'd0, in_item_i.channel} >= 32'(Channels));
  assign raddr = AddrW'(in_item_i.channel);

  assign adv3 = !v3_q || out_ready_i;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign in_ready_o = adv1;

  bn_ram #(.Width(32), .Depth(Channels)) u_scale (
    .clk_i, .we_i(wr_i.valid), .waddr_i(AddrW'(wr_i.channel)), .wdata_i(wr_i.scale),
    .re_i(adv1 && in_valid_i), .raddr_i(raddr), .rdata_o(scale_rd));
  bn_ram #(.Width(32), .Depth(Channels)) u_shift (
    .clk_i, .we_i(wr_i.valid), .waddr_i(AddrW'(wr_i.channel)), .wdata_i(wr_i.shift),
    .re_i(adv1 && in_valid_i), .raddr_i(raddr), .rdata_o(shift_rd));
  bn_ram #(.Width(1), .Depth(Channels)) u_clip (
    .clk_i, .we_i(wr_i.valid), .waddr_i(AddrW'(wr_i.channel)), .wdata_i(wr_i.clipped),
    .re_i(adv1 && in_valid_i), .raddr_i(raddr), .rdata_o(clip_rd));

  // round half away from zero; negative values use a bias one below half
  assign r = acc2_q[47] ? ((acc2_q + 48'sd32767) >>> 16)
                        : ((acc2_q + 48'sd32768) >>> 16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      ch1_q  <= in_item_i.channel;
      oor1_q <= oor;
      smp1_q <= in_item_i.sample;
    end
    if (adv2) begin
      ch2_q   <= ch1_q;
      oor2_q  <= oor1_q;
      clip2_q <= clip_rd[0];
      acc2_q  <= 48'(smp1_q) * 48'(scale_rd) + (48'(shift_rd) <<< 16);
    end
    if (adv3) begin
      res_q.result_channel <= ch2_q;
      if (oor2_q) begin
        res_q.result    <= '0;
        res_q.saturated <= 1'b1;
      end else if (r > Hi - 48'sd1) begin
        res_q.result    <= 16'(Hi - 48'sd1);
        res_q.saturated <= 1'b1;
      end else if (r < -Hi) begin
        res_q.result    <= 16'(-Hi);
        res_q.saturated <= 1'b1;
      end else begin
        res_q.result    <= 16'(r);
        res_q.saturated <= clip2_q;
      end
    end
  end

  assign out_valid_o = v3_q;
  assign out_item_o  = res_q;
endmodule

### rtl/core/batch_norm_inference.sv
// Top level of per-channel batch normalization for inference.
// Depends on bn_pkg, bn_stream_if, bn_fifo, bn_loader, bn_datapath.
`timescale 1ns / 1ps
// Usage:
//   in_if carries load items (operation 0) and sample items (operation 1);
//   out_if carries one result per sample item. Configuration is a plain
//   write port (cfg_we_i, cfg_idx_i, cfg_data_i), written while idle.
// Throughput: samples flow one per cycle while out_if.ready is high,
//   through a two-entry queue into a three-stage table-read / multiply /
//   round pipeline. A load runs in the coefficient unit: 29 square-root
//   steps and 49 divide steps (skipped when variance plus epsilon is
//   zero), a shift product and a table write; the front takes no further
//   item until the queue has drained and the load is stored.
// Reset: clears pipeline valids, queue and control; epsilon returns to 1,
//   use_weight and use_bias to 0. Tables are undefined until loaded.
// Stall: when out_if.ready is low the pipeline holds, the queue fills and
//   in_if.ready drops.
module batch_norm_inference #(
  parameter int unsigned CHANNELS   = 64,
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bn_stream_if.sink                     in_if,
  bn_stream_if.source                   out_if,
  input  logic                          cfg_we_i,
  input  logic [bn_pkg::RegIdxW-1:0]    cfg_idx_i,
  input  logic [bn_pkg::RegDataW-1:0]   cfg_data_i
);
  logic [15:0] epsilon_q;
  logic        use_weight_q, use_bias_q;
  logic        fifo_full, fifo_empty, fifo_pop;
  bn_pkg::in_item_t fifo_data;
  logic        ld_busy, ld_start, push, dp_ready;
  bn_pkg::coef_wr_t wr;
  logic        is_load;

  assign is_load = (in_if.data.operation == bn_pkg::OP_LOAD);
  // a load waits for queued samples to finish reading the old table
  assign in_if.ready = !ld_busy && (is_load ? fifo_empty : !fifo_full);
  assign ld_start = in_if.valid && in_if.ready && is_load &&
                    ({26'd0, in_if.data.channel} < 32'(CHANNELS));
  assign push = in_if.valid && in_if.ready && !is_load;
  assign fifo_pop = !fifo_empty && dp_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epsilon_q    <= 16'd1;
      use_weight_q <= 1'b0;
      use_bias_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bn_pkg::REG_EPSILON:    epsilon_q    <= cfg_data_i;
        bn_pkg::REG_USE_WEIGHT: use_weight_q <= cfg_data_i[0];
        bn_pkg::REG_USE_BIAS:   use_bias_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  bn_fifo #(.Depth(2)) u_fifo (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(in_if.data), .full_o(fifo_full),
    .pop_i(fifo_pop), .pop_data_o(fifo_data), .empty_o(fifo_empty));

  bn_loader u_loader (
    .clk_i, .rst_ni, .start_i(ld_start), .item_i(in_if.data),
    .epsilon_i(epsilon_q), .use_weight_i(use_weight_q), .use_bias_i(use_bias_q),
    .busy_o(ld_busy), .wr_o(wr));

  bn_datapath #(.Channels(CHANNELS), .DataWidth(DATA_WIDTH)) u_dp (
    .clk_i, .rst_ni, .wr_i(wr), .in_valid_i(!fifo_empty), .in_item_i(fifo_data),
    .in_ready_o(dp_ready), .out_valid_o(out_if.valid), .out_item_o(out_if.data),
    .out_ready_i(out_if.ready));
endmodule
